// ===== hw/rtl/cdate_pkg.sv =====
// Types, constants and calendar functions shared by the date block.
package cdate_pkg;

  localparam int YEAR_BITS  = 16;
  localparam int COUNT_BITS = 20;
  localparam int DAY_W      = 5;
  localparam int MON_W      = 4;
  localparam int LEN_W      = 9;
  localparam int ORD_W      = (COUNT_BITS >= 18) ? COUNT_BITS + 1 : 19;

  localparam int CYCLE_DAYS  = 146097;
  localparam int CYCLE_YEARS = 400;

  localparam logic [YEAR_BITS-1:0] YEAR_MAX  = {YEAR_BITS{1'b1}};
  localparam logic [YEAR_BITS-1:0] CYC_YEARS = YEAR_BITS'(CYCLE_YEARS);
  localparam logic [ORD_W-1:0]     CYC_DAYS  = ORD_W'(CYCLE_DAYS);
  localparam logic [YEAR_BITS-1:0] DIV25_LIM = YEAR_BITS'(YEAR_MAX / 25);

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ADD  = 2'd1,
    OP_SUB  = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LOAD = 2'd1,
    ST_SAT      = 2'd2
  } st_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_LOAD,
    CMD_CYC_STEP,
    CMD_SAT,
    CMD_ADD_INIT,
    CMD_ADD_STEP,
    CMD_SUB_INIT,
    CMD_SUB_STEP_ORD,
    CMD_SUB_END_ORD,
    CMD_SUB_STEP_LEN,
    CMD_SUB_END_LEN,
    CMD_MONTH_STEP,
    CMD_MONTH_END,
    CMD_EMIT
  } dp_cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LOAD,
    S_ADD_CYC,
    S_ADD_YEAR,
    S_SUB_CYC,
    S_SUB_FIRST,
    S_SUB_YEAR,
    S_MONTH,
    S_FINISH
  } state_e;

  typedef struct packed {
    op_e  op;
    logic cyc_go;
    logic year_lim;
    logic add_over;
    logic sub_ord_go;
    logic sub_len_go;
    logic month_go;
    logic out_free;
  } dp_stat_t;

  // multiplicative inverse of 25 modulo 2^YEAR_BITS
  function automatic logic [YEAR_BITS-1:0] inv25();
    logic [YEAR_BITS-1:0] x;
    x = YEAR_BITS'(1);
    for (int i = 0; i < 6; i++) begin
      x = x * (YEAR_BITS'(2) - YEAR_BITS'(25) * x);
    end
    return x;
  endfunction

  localparam logic [YEAR_BITS-1:0] INV25 = inv25();

  function automatic logic leap_of(input logic [YEAR_BITS-1:0] y);
    logic [YEAR_BITS-1:0] prod;
    logic                 div25;
    prod  = y * INV25;
    div25 = (prod <= DIV25_LIM);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      MON_W'(2):                                          len = leap ? DAY_W'(29) : DAY_W'(28);
      MON_W'(4), MON_W'(6), MON_W'(9), MON_W'(11):        len = DAY_W'(30);
      default:                                            len = DAY_W'(31);
    endcase
    return len;
  endfunction

  function automatic logic [LEN_W-1:0] days_before(input logic [MON_W-1:0] m);
    logic [LEN_W-1:0] d;
    unique case (m)
      MON_W'(2):  d = LEN_W'(31);
      MON_W'(3):  d = LEN_W'(59);
      MON_W'(4):  d = LEN_W'(90);
      MON_W'(5):  d = LEN_W'(120);
      MON_W'(6):  d = LEN_W'(151);
      MON_W'(7):  d = LEN_W'(181);
      MON_W'(8):  d = LEN_W'(212);
      MON_W'(9):  d = LEN_W'(243);
      MON_W'(10): d = LEN_W'(273);
      MON_W'(11): d = LEN_W'(304);
      MON_W'(12): d = LEN_W'(334);
      default:    d = LEN_W'(0);
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/cdate_dp.sv =====
// Datapath: date registers, day counter, ordinal, leap unit and output word register.
module cdate_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cdate_pkg::dp_cmd_e               cmd_i,
  output cdate_pkg::dp_stat_t              stat_o,
  input  logic [1:0]                       opcode_i,
  input  logic [cdate_pkg::DAY_W-1:0]      load_day_i,
  input  logic [cdate_pkg::MON_W-1:0]      load_month_i,
  input  logic [cdate_pkg::YEAR_BITS-1:0]  load_year_i,
  input  logic [cdate_pkg::COUNT_BITS-1:0] day_count_i,
  input  logic                             out_stall_i,
  output logic                             out_valid_o,
  output logic [cdate_pkg::DAY_W-1:0]      out_day_o,
  output logic [cdate_pkg::MON_W-1:0]      out_month_o,
  output logic [cdate_pkg::YEAR_BITS-1:0]  out_year_o,
  output logic                             is_leap_o,
  output logic [1:0]                       status_o
);
  import cdate_pkg::*;

  op_e                   op_q, op_d;
  logic [DAY_W-1:0]      ld_day_q, ld_day_d;
  logic [MON_W-1:0]      ld_mon_q, ld_mon_d;
  logic [YEAR_BITS-1:0]  ld_year_q, ld_year_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [ORD_W-1:0]      ord_q, ord_d;
  logic [DAY_W-1:0]      day_q, day_d;
  logic [MON_W-1:0]      mon_q, mon_d;
  logic [YEAR_BITS-1:0]  year_q, year_d;
  st_e                   st_q, st_d;

  logic                  out_valid_q;
  logic [DAY_W-1:0]      out_day_q;
  logic [MON_W-1:0]      out_mon_q;
  logic [YEAR_BITS-1:0]  out_year_q;
  logic                  out_leap_q;
  st_e                   out_st_q;

  logic [YEAR_BITS-1:0]  leap_year;
  logic                  leap;
  logic [LEN_W-1:0]      ylen;
  logic [DAY_W-1:0]      mlen;
  logic [DAY_W-1:0]      ld_mlen;
  logic [LEN_W-1:0]      doy;
  logic [ORD_W-1:0]      cnt_ext;
  logic                  load_ok;

  assign leap_year = (cmd_i == CMD_LOAD) ? ld_year_q : year_q;
  assign leap      = leap_of(leap_year);
  assign ylen      = leap ? LEN_W'(366) : LEN_W'(365);
  assign mlen      = month_len(mon_q, leap);
  assign ld_mlen   = month_len(ld_mon_q, leap);
  assign doy       = days_before(mon_q) + LEN_W'(day_q)
                   + LEN_W'(leap && (mon_q > MON_W'(2)));
  assign cnt_ext   = ORD_W'(cnt_q);
  assign load_ok   = (ld_mon_q >= MON_W'(1)) && (ld_mon_q <= MON_W'(12))
                   && (ld_day_q != '0) && (ld_day_q <= ld_mlen);

  always_comb begin
    stat_o.op         = op_q;
    stat_o.cyc_go     = (cnt_ext >= CYC_DAYS) &&
                        ((op_q == OP_ADD) ? (year_q <= YEAR_MAX - CYC_YEARS)
                                          : (year_q >= CYC_YEARS));
    stat_o.year_lim   = (op_q == OP_ADD) ? (year_q == YEAR_MAX) : (year_q == '0);
    stat_o.add_over   = ord_q > ORD_W'(ylen);
    stat_o.sub_ord_go = cnt_ext >= ord_q;
    stat_o.sub_len_go = cnt_ext >= ORD_W'(ylen);
    stat_o.month_go   = (mon_q < MON_W'(12)) && (ord_q > ORD_W'(mlen));
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    op_d      = op_q;
    ld_day_d  = ld_day_q;
    ld_mon_d  = ld_mon_q;
    ld_year_d = ld_year_q;
    cnt_d     = cnt_q;
    ord_d     = ord_q;
    day_d     = day_q;
    mon_d     = mon_q;
    year_d    = year_q;
    st_d      = st_q;
    unique case (cmd_i)
      CMD_CAPTURE: begin
        op_d      = op_e'(opcode_i);
        ld_day_d  = load_day_i;
        ld_mon_d  = load_month_i;
        ld_year_d = load_year_i;
        cnt_d     = day_count_i;
        st_d      = ST_OK;
      end
      CMD_LOAD: begin
        if (load_ok) begin
          day_d  = ld_day_q;
          mon_d  = ld_mon_q;
          year_d = ld_year_q;
        end else begin
          st_d = ST_BAD_LOAD;
        end
      end
      CMD_CYC_STEP: begin
        cnt_d  = COUNT_BITS'(cnt_ext - CYC_DAYS);
        year_d = (op_q == OP_ADD) ? year_q + CYC_YEARS : year_q - CYC_YEARS;
      end
      CMD_SAT: begin
        st_d = ST_SAT;
        if (op_q == OP_ADD) begin
          day_d = DAY_W'(31);
          mon_d = MON_W'(12);
        end else begin
          day_d = DAY_W'(1);
          mon_d = MON_W'(1);
        end
      end
      CMD_ADD_INIT: begin
        ord_d = ORD_W'(doy) + cnt_ext;
        mon_d = MON_W'(1);
      end
      CMD_ADD_STEP: begin
        ord_d  = ord_q - ORD_W'(ylen);
        year_d = year_q + YEAR_BITS'(1);
      end
      CMD_SUB_INIT: begin
        ord_d = ORD_W'(doy);
      end
      CMD_SUB_STEP_ORD: begin
        cnt_d  = COUNT_BITS'(cnt_ext - ord_q);
        year_d = year_q - YEAR_BITS'(1);
      end
      CMD_SUB_END_ORD: begin
        ord_d = ord_q - cnt_ext;
        mon_d = MON_W'(1);
      end
      CMD_SUB_STEP_LEN: begin
        cnt_d  = COUNT_BITS'(cnt_ext - ORD_W'(ylen));
        year_d = year_q - YEAR_BITS'(1);
      end
      CMD_SUB_END_LEN: begin
        ord_d = ORD_W'(ylen) - cnt_ext;
        mon_d = MON_W'(1);
      end
      CMD_MONTH_STEP: begin
        ord_d = ord_q - ORD_W'(mlen);
        mon_d = mon_q + MON_W'(1);
      end
      CMD_MONTH_END: begin
        day_d = ord_q[DAY_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_q       <= DAY_W'(1);
      mon_q       <= MON_W'(1);
      year_q      <= YEAR_BITS'(2000);
      out_valid_q <= 1'b0;
    end else begin
      day_q  <= day_d;
      mon_q  <= mon_d;
      year_q <= year_d;
      if (cmd_i == CMD_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    ld_day_q  <= ld_day_d;
    ld_mon_q  <= ld_mon_d;
    ld_year_q <= ld_year_d;
    cnt_q     <= cnt_d;
    ord_q     <= ord_d;
    st_q      <= st_d;
    if (cmd_i == CMD_EMIT) begin
      out_day_q  <= day_q;
      out_mon_q  <= mon_q;
      out_year_q <= year_q;
      out_leap_q <= leap;
      out_st_q   <= st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_day_o   = out_day_q;
  assign out_month_o = out_mon_q;
  assign out_year_o  = out_year_q;
  assign is_leap_o   = out_leap_q;
  assign status_o    = out_st_q;

endmodule

// ===== hw/rtl/cdate_ctrl.sv =====
// Controller: sequences load, add and subtract words through the datapath.
module cdate_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cdate_pkg::dp_stat_t stat_i,
  output cdate_pkg::dp_cmd_e  cmd_o
);
  import cdate_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (stat_i.op)
          OP_LOAD: state_d = S_LOAD;
          OP_ADD:  state_d = S_ADD_CYC;
          OP_SUB:  state_d = S_SUB_CYC;
          default: state_d = S_FINISH;
        endcase
      end
      S_LOAD: state_d = S_FINISH;
      S_ADD_CYC: begin
        if (!stat_i.cyc_go) state_d = S_ADD_YEAR;
      end
      S_ADD_YEAR: begin
        priority if (stat_i.add_over && stat_i.year_lim) state_d = S_FINISH;
        else if (!stat_i.add_over) state_d = S_MONTH;
        else state_d = S_ADD_YEAR;
      end
      S_SUB_CYC: begin
        if (!stat_i.cyc_go) state_d = S_SUB_FIRST;
      end
      S_SUB_FIRST: begin
        priority if (stat_i.sub_ord_go && stat_i.year_lim) state_d = S_FINISH;
        else if (stat_i.sub_ord_go) state_d = S_SUB_YEAR;
        else state_d = S_MONTH;
      end
      S_SUB_YEAR: begin
        priority if (stat_i.sub_len_go && stat_i.year_lim) state_d = S_FINISH;
        else if (!stat_i.sub_len_go) state_d = S_MONTH;
        else state_d = S_SUB_YEAR;
      end
      S_MONTH: begin
        if (!stat_i.month_go) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = CMD_NONE;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) cmd_o = CMD_CAPTURE;
      end
      S_LOAD: cmd_o = CMD_LOAD;
      S_ADD_CYC: begin
        cmd_o = stat_i.cyc_go ? CMD_CYC_STEP : CMD_ADD_INIT;
      end
      S_ADD_YEAR: begin
        priority if (stat_i.add_over && stat_i.year_lim) cmd_o = CMD_SAT;
        else if (stat_i.add_over) cmd_o = CMD_ADD_STEP;
        else cmd_o = CMD_NONE;
      end
      S_SUB_CYC: begin
        cmd_o = stat_i.cyc_go ? CMD_CYC_STEP : CMD_SUB_INIT;
      end
      S_SUB_FIRST: begin
        priority if (stat_i.sub_ord_go && stat_i.year_lim) cmd_o = CMD_SAT;
        else if (stat_i.sub_ord_go) cmd_o = CMD_SUB_STEP_ORD;
        else cmd_o = CMD_SUB_END_ORD;
      end
      S_SUB_YEAR: begin
        priority if (stat_i.sub_len_go && stat_i.year_lim) cmd_o = CMD_SAT;
        else if (stat_i.sub_len_go) cmd_o = CMD_SUB_STEP_LEN;
        else cmd_o = CMD_SUB_END_LEN;
      end
      S_MONTH: begin
        cmd_o = stat_i.month_go ? CMD_MONTH_STEP : CMD_MONTH_END;
      end
      S_FINISH: begin
        if (stat_i.out_free) cmd_o = CMD_EMIT;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/calendar_date_add_subtract_days.sv =====
// Top level of the Gregorian date register with add and subtract of day counts.
// Holds one proleptic Gregorian date (reset 1 January 2000, year 0 is leap) and
// returns one result word per input word: the date after the step, its leap flag
// and a status (ok, rejected load, saturated year). Words are processed one at a
// time. Add and subtract first take 400-year jumps (at most 7 for a 20-bit count),
// then cross years one at a time and then walk the months (at most 11 steps); the
// year walk, stepping one year a cycle through the shared leap-year unit, sets the
// run time, most of all when jumps are blocked near the year range limits. The
// result register frees the input side once a word is issued.
module calendar_date_add_subtract_days (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       opcode_i,
  input  logic [cdate_pkg::DAY_W-1:0]      load_day_i,
  input  logic [cdate_pkg::MON_W-1:0]      load_month_i,
  input  logic [cdate_pkg::YEAR_BITS-1:0]  load_year_i,
  input  logic [cdate_pkg::COUNT_BITS-1:0] day_count_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [cdate_pkg::DAY_W-1:0]      out_day_o,
  output logic [cdate_pkg::MON_W-1:0]      out_month_o,
  output logic [cdate_pkg::YEAR_BITS-1:0]  out_year_o,
  output logic                             is_leap_o,
  output logic [1:0]                       status_o
);
  import cdate_pkg::*;

  dp_cmd_e  cmd;
  dp_stat_t stat;

  cdate_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cdate_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .opcode_i     (opcode_i),
    .load_day_i   (load_day_i),
    .load_month_i (load_month_i),
    .load_year_i  (load_year_i),
    .day_count_i  (day_count_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_day_o    (out_day_o),
    .out_month_o  (out_month_o),
    .out_year_o   (out_year_o),
    .is_leap_o    (is_leap_o),
    .status_o     (status_o)
  );

endmodule
